[hw/rtl/bchd_pkg.sv]
// Shared types and constants for the button click and hold detector.
`timescale 1ns / 1ps
package bchd_pkg;

  localparam logic [31:0] DEBOUNCE_MS = 32'd20;
  localparam logic [16:0] LATCH_EXTRA_MS = 17'd500;
  localparam logic [7:0] SAT8 = 8'd255;
  localparam logic [2:0] CLICK_SAT = 3'd5;
  localparam logic [7:0] PERCENT_SCALE = 8'd100;

  localparam logic KIND_POLL = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_SINGLE = 3'd1;
  localparam logic [2:0] EV_HOLD = 3'd6;
  localparam logic [2:0] EV_HOLD_REL = 3'd7;

  localparam logic [2:0] NOTIFY_NONE = 3'd0;
  localparam logic [2:0] NOTIFY_SINGLE = 3'd1;
  localparam logic [2:0] NOTIFY_TRIPLE = 3'd3;
  localparam logic [2:0] NOTIFY_LONG = 3'd4;

  localparam logic [1:0] TYPE_UNKNOWN = 2'd0;
  localparam logic [1:0] TYPE_LATCH = 2'd1;
  localparam logic [1:0] TYPE_MOMENTARY = 2'd2;

  localparam logic [2:0] REG_DOUBLE_WIN = 3'd0;
  localparam logic [2:0] REG_MULTI_WIN = 3'd1;
  localparam logic [2:0] REG_HOLD = 3'd2;
  localparam logic [2:0] REG_MIN_CLICK = 3'd3;
  localparam logic [2:0] REG_MAX_CLICKS = 3'd4;
  localparam logic [2:0] REG_MOM_LIMIT = 3'd5;
  localparam logic [2:0] REG_MIN_SAMPLES = 3'd6;
  localparam logic [2:0] REG_MOM_PERCENT = 3'd7;

  typedef struct packed {
    logic        level;
    logic [31:0] edge_time;
    logic        prev_level;
    logic [31:0] press_start;
    logic [31:0] click_time;
    logic [2:0]  clicks;
    logic        holding;
    logic [2:0]  pending;
    logic        hold_rep;
    logic [1:0]  type_class;
    logic [7:0]  releases;
    logic [7:0]  votes;
    logic [31:0] press_time;
    logic        press_seen;
  } chan_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_STORE
  } state_t;

  typedef struct packed {
    logic load;
    logic p1;
    logic p2;
    logic p3;
    logic p4;
    logic store;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/bchd_ctrl.sv]
// Sequencer for the detector: loads a channel, runs four update steps, writes back.
`timescale 1ns / 1ps
module bchd_ctrl import bchd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;
  logic accept;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_P1;
      end
      ST_P1: state_next = ST_P2;
      ST_P2: state_next = ST_P3;
      ST_P3: state_next = ST_P4;
      ST_P4: state_next = ST_STORE;
      ST_STORE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_P1: cmd.p1 = 1'b1;
      ST_P2: cmd.p2 = 1'b1;
      ST_P3: cmd.p3 = 1'b1;
      ST_P4: cmd.p4 = 1'b1;
      ST_STORE: cmd.store = sts.out_free;
      default: in_stall = 1'b1;
    endcase
  end

  a_accept_p1: assert property (@(posedge clk) disable iff (rst) accept |=> state == ST_P1)
    else $error("accepted transaction did not start processing");
  a_p4_store: assert property (@(posedge clk) disable iff (rst) state == ST_P4 |=> state == ST_STORE)
    else $error("last step did not go to write-back");
  a_store_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STORE && !sts.out_free) |=> state == ST_STORE)
    else $error("write-back left while output was full");

endmodule

[hw/rtl/bchd_dp.sv]
// Datapath: per-channel state, configuration registers, update steps and result register.
`timescale 1ns / 1ps
module bchd_dp import bchd_pkg::*; #(
  parameter int CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        kind,
  input  logic [3:0]  channel,
  input  logic        raw_level,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  channel_out,
  output logic [2:0]  notify_code,
  output logic [2:0]  event_res,
  output logic [1:0]  input_type,
  output logic        level_out
);

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  chan_t arr [CHANNELS];
  chan_t w, wn;

  logic [15:0] double_win, multi_win, hold_ms, min_click, mom_limit;
  logic [2:0]  max_clicks;
  logic [7:0]  min_samples;
  logic [6:0]  mom_percent;

  logic        it_kind, it_raw, it_ok;
  logic [3:0]  it_ch;
  logic [31:0] it_now;
  logic [IW-1:0] it_idx, in_idx;
  logic        in_ok;

  logic rise, rise_next, fall, fall_next, click_ok, click_ok_next;
  logic [2:0]  notify, notify_next, fev, fev_next;
  logic [14:0] prod_a, prod_a_next;
  logic [15:0] prod_b, prod_b_next;

  logic [31:0] d_edge, d_click, d_start, d_press;
  logic [16:0] latch_lim;
  logic        lvl_new;
  logic [2:0]  eff_max, n_notify;

  assign in_idx = IW'({{IW{1'b0}}, channel});
  assign in_ok = ({{IW{1'b0}}, channel} < (IW + 4)'(CHANNELS));

  assign d_edge = it_now - w.edge_time;
  assign d_click = it_now - w.click_time;
  assign d_start = it_now - w.press_start;
  assign d_press = it_now - w.press_time;
  assign latch_lim = {1'b0, mom_limit} + LATCH_EXTRA_MS;
  assign lvl_new = ((it_raw != w.level) && (d_edge > DEBOUNCE_MS)) ? it_raw : w.level;
  assign eff_max = (max_clicks == 3'd0) ? 3'd1 : ((max_clicks > CLICK_SAT) ? CLICK_SAT : max_clicks);
  assign n_notify = (w.clicks >= 3'd3) ? NOTIFY_TRIPLE : w.clicks;

  assign sts.out_free = !out_valid || !out_stall;

  always_comb begin
    wn = w;
    rise_next = rise;
    fall_next = fall;
    click_ok_next = click_ok;
    notify_next = notify;
    fev_next = fev;
    prod_a_next = prod_a;
    prod_b_next = prod_b;
    if (cmd.load) begin
      wn = arr[in_idx];
      notify_next = NOTIFY_NONE;
      rise_next = 1'b0;
      fall_next = 1'b0;
    end
    if (cmd.p1) begin
      if (it_kind == KIND_POLL) begin
        wn.prev_level = w.level;
        wn.level = lvl_new;
        if (it_raw != w.level) wn.edge_time = it_now;
        rise_next = lvl_new && !w.level;
        fall_next = !lvl_new && w.level;
        if (lvl_new && !w.level) begin
          wn.press_start = it_now;
          wn.hold_rep = 1'b0;
          wn.press_time = it_now;
          wn.press_seen = 1'b1;
          if (!((w.clicks != 3'd0) &&
                (d_click < {16'd0, multi_win} || d_click < {16'd0, double_win}))) begin
            wn.clicks = 3'd0;
            wn.pending = EV_NONE;
          end
        end
      end else begin
        fev_next = w.pending;
        wn.pending = EV_NONE;
      end
    end
    if (cmd.p2 && it_kind == KIND_POLL) begin
      if (w.level && !w.hold_rep) begin
        if (w.type_class == TYPE_UNKNOWN && w.press_seen && d_press >= {15'd0, latch_lim})
          wn.type_class = TYPE_LATCH;
        if (d_start >= {16'd0, hold_ms}) begin
          wn.holding = 1'b1;
          wn.hold_rep = 1'b1;
          wn.pending = EV_HOLD;
          wn.clicks = 3'd0;
          notify_next = NOTIFY_LONG;
        end
      end
      if (fall) begin
        if (w.releases < SAT8) wn.releases = w.releases + 8'd1;
        if (d_start < {16'd0, mom_limit} && w.votes < SAT8) wn.votes = w.votes + 8'd1;
        click_ok_next = d_start >= {16'd0, min_click};
      end
    end
    if (cmd.p3) begin
      prod_a_next = {7'd0, w.votes} * {8'd0, PERCENT_SCALE[6:0]};
      prod_b_next = {8'd0, {1'b0, mom_percent} + 8'd1} * {8'd0, w.releases};
      if (it_kind == KIND_POLL && fall) begin
        if (w.holding) begin
          wn.holding = 1'b0;
          wn.pending = EV_HOLD_REL;
        end else if (click_ok) begin
          if (w.clicks < CLICK_SAT) wn.clicks = w.clicks + 3'd1;
          wn.click_time = it_now;
          wn.pending = EV_NONE;
        end
      end
    end
    if (cmd.p4 && it_kind == KIND_POLL) begin
      if (fall && w.type_class == TYPE_UNKNOWN && w.releases >= min_samples)
        wn.type_class = ({1'b0, prod_a} >= prod_b) ? TYPE_MOMENTARY : TYPE_LATCH;
      if (!w.level && w.clicks != 3'd0 && !w.holding) begin
        if (w.clicks >= eff_max) begin
          wn.pending = w.clicks;
          notify_next = n_notify;
          wn.clicks = 3'd0;
        end else if (d_click > {16'd0, double_win} && w.clicks == 3'd1) begin
          wn.pending = EV_SINGLE;
          notify_next = NOTIFY_SINGLE;
          wn.clicks = 3'd0;
        end else if (d_click > {16'd0, multi_win} && w.clicks >= 3'd2) begin
          wn.pending = w.clicks;
          notify_next = n_notify;
          wn.clicks = 3'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    w <= wn;
    rise <= rise_next;
    fall <= fall_next;
    click_ok <= click_ok_next;
    notify <= notify_next;
    fev <= fev_next;
    prod_a <= prod_a_next;
    prod_b <= prod_b_next;
    if (cmd.load) begin
      it_kind <= kind;
      it_raw <= raw_level;
      it_ch <= channel;
      it_now <= now_ms;
      it_idx <= in_idx;
      it_ok <= in_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) arr[i] <= '0;
    end else if (cmd.store && it_ok) begin
      arr[it_idx] <= w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      double_win <= 16'd350;
      multi_win <= 16'd200;
      hold_ms <= 16'd500;
      min_click <= 16'd50;
      max_clicks <= 3'd5;
      mom_limit <= 16'd1000;
      min_samples <= 8'd3;
      mom_percent <= 7'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DOUBLE_WIN: double_win <= cfg_data;
        REG_MULTI_WIN: multi_win <= cfg_data;
        REG_HOLD: hold_ms <= cfg_data;
        REG_MIN_CLICK: min_click <= cfg_data;
        REG_MAX_CLICKS: max_clicks <= cfg_data[2:0];
        REG_MOM_LIMIT: mom_limit <= cfg_data;
        REG_MIN_SAMPLES: min_samples <= cfg_data[7:0];
        REG_MOM_PERCENT: mom_percent <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.store) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      channel_out <= it_ch;
      notify_code <= it_ok ? notify : NOTIFY_NONE;
      event_res <= it_ok ? ((it_kind == KIND_FETCH) ? fev : w.pending) : EV_NONE;
      input_type <= it_ok ? w.type_class : TYPE_UNKNOWN;
      level_out <= it_ok && w.level;
    end
  end

endmodule

[hw/rtl/button_click_hold_detector_core.sv]
// Button click and hold detector, top level.
// Qualifies button levels per channel: debounce, click counting, hold and
// latch/momentary classification.
// Input channel: in_valid/in_stall with kind, channel, raw_level, now_ms. A poll
// (kind 0) updates the channel; a fetch (kind 1) returns and clears its pending event.
// Output channel: out_valid/out_stall, one result transaction per input transaction.
// Configuration: cfg_we, cfg_index, cfg_data; to be written only while idle (not enforced by the block).
// Each transaction runs from acceptance to the result register as follows: the load
// happens at the accepting edge, then four update steps over the loaded channel
// state and one write-back. The next transaction is accepted the cycle after
// write-back, so a new transaction is not taken before the last one is through,
// set by the update sequence over the single channel state copy.
// A result waiting under out_stall holds; write-back of the following transaction
// waits until the output register is free.
// Reset clears all channel state and loads register defaults; out_valid drops.
`timescale 1ns / 1ps
module button_click_hold_detector_core import bchd_pkg::*; #(
  parameter int CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [3:0]  channel,
  input  logic        raw_level,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  channel_out,
  output logic [2:0]  notify_code,
  output logic [2:0]  event_res,
  output logic [1:0]  input_type,
  output logic        level_out
);

  cmd_t cmd;
  sts_t sts;

  bchd_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts(sts),
    .cmd(cmd)
  );

  bchd_dp #(.CHANNELS(CHANNELS)) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .sts(sts),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .kind(kind),
    .channel(channel),
    .raw_level(raw_level),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .channel_out(channel_out),
    .notify_code(notify_code),
    .event_res(event_res),
    .input_type(input_type),
    .level_out(level_out)
  );

endmodule

[sim/tb_button_click_hold_detector_core.sv]
// Testbench for the button click and hold detector core with a built-in predictor.
`timescale 1ns / 1ps
module tb_button_click_hold_detector_core;
  import bchd_pkg::*;

  typedef struct {
    logic        kind;
    logic [3:0]  channel;
    logic        raw_level;
    logic [31:0] now_ms;
  } poll_t;

  typedef struct {
    logic [3:0] channel_out;
    logic [2:0] notify_code;
    logic [2:0] event_res;
    logic [1:0] input_type;
    logic       level_out;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_DOUBLE_WIN;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = KIND_POLL;
  logic [3:0] channel = '0;
  logic raw_level = 1'b0;
  logic [31:0] now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] channel_out;
  logic [2:0] notify_code;
  logic [2:0] event_res;
  logic [1:0] input_type;
  logic level_out;

  button_click_hold_detector_core dut (.*);

  always #10 clk = ~clk;

  // predictor state
  chan_t btn [16];
  logic [15:0] win_double, win_multi, hold_len, min_click, mom_limit;
  logic [2:0] max_clk;
  logic [7:0] min_samp;
  logic [6:0] mom_pct;

  poll_t pending_polls[$];
  result_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int sent = 0;
  logic stim_done = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  logic [31:0] clock_ms [16];
  logic in_stall_q = 1'b1;
  logic hold_off = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic apply_cfg(input logic [2:0] idx, input logic [15:0] val);
    case (idx)
      REG_DOUBLE_WIN: win_double = val;
      REG_MULTI_WIN: win_multi = val;
      REG_HOLD: hold_len = val;
      REG_MIN_CLICK: min_click = val;
      REG_MAX_CLICKS: max_clk = val[2:0];
      REG_MOM_LIMIT: mom_limit = val;
      REG_MIN_SAMPLES: min_samp = val[7:0];
      default: mom_pct = val[6:0];
    endcase
  endtask

  function automatic result_t predict_button(input poll_t p);
    result_t r;
    chan_t c;
    logic [2:0] nt;
    logic [31:0] since, dur, ratio;
    logic [2:0] emax, n;
    logic rise, fall;
    r = '{p.channel, NOTIFY_NONE, EV_NONE, TYPE_UNKNOWN, 1'b0};
    c = btn[p.channel];
    nt = NOTIFY_NONE;
    if (p.kind == KIND_FETCH) begin
      r.event_res = c.pending;
      c.pending = EV_NONE;
    end else begin
      c.prev_level = c.level;
      if (p.raw_level != c.level) begin
        if (p.now_ms - c.edge_time > DEBOUNCE_MS) c.level = p.raw_level;
        c.edge_time = p.now_ms;
      end
      rise = c.level && !c.prev_level;
      fall = !c.level && c.prev_level;
      if (rise) begin
        since = p.now_ms - c.click_time;
        c.press_start = p.now_ms;
        c.hold_rep = 1'b0;
        c.press_time = p.now_ms;
        c.press_seen = 1'b1;
        if (!(c.clicks > 0 && (since < win_multi || since < win_double))) begin
          c.clicks = 3'd0;
          c.pending = EV_NONE;
        end
      end
      if (c.level && !c.hold_rep) begin
        since = p.now_ms - c.press_time;
        if (c.type_class == TYPE_UNKNOWN && c.press_seen &&
            since >= 32'(mom_limit) + 32'(LATCH_EXTRA_MS))
          c.type_class = TYPE_LATCH;
        if (p.now_ms - c.press_start >= 32'(hold_len)) begin
          c.holding = 1'b1;
          c.hold_rep = 1'b1;
          c.pending = EV_HOLD;
          c.clicks = 3'd0;
          nt = NOTIFY_LONG;
        end
      end
      if (fall) begin
        dur = p.now_ms - c.press_start;
        if (c.releases < SAT8) c.releases++;
        if (dur < 32'(mom_limit) && c.votes < SAT8) c.votes++;
        if (c.type_class == TYPE_UNKNOWN && c.releases >= min_samp) begin
          ratio = (32'(c.votes) * 100) / c.releases;
          c.type_class = (ratio > 32'(mom_pct)) ? TYPE_MOMENTARY : TYPE_LATCH;
        end
        if (c.holding) begin
          c.holding = 1'b0;
          c.pending = EV_HOLD_REL;
        end else if (dur >= 32'(min_click)) begin
          if (c.clicks < CLICK_SAT) c.clicks++;
          c.click_time = p.now_ms;
          c.pending = EV_NONE;
        end
      end
      if (!c.level && c.clicks > 0 && !c.holding) begin
        since = p.now_ms - c.click_time;
        n = c.clicks;
        emax = (max_clk == 0) ? 3'd1 : (max_clk > 5) ? 3'd5 : max_clk;
        if (n >= emax) begin
          c.pending = n;
          nt = (n >= 4) ? NOTIFY_TRIPLE : n;
          c.clicks = 3'd0;
        end else if (since > 32'(win_double) && n == 1) begin
          c.pending = EV_SINGLE;
          nt = NOTIFY_SINGLE;
          c.clicks = 3'd0;
        end else if (since > 32'(win_multi) && n >= 2) begin
          c.pending = n;
          nt = (n >= 3) ? NOTIFY_TRIPLE : n;
          c.clicks = 3'd0;
        end
      end
      r.event_res = c.pending;
    end
    r.notify_code = nt;
    r.input_type = c.type_class;
    r.level_out = c.level;
    btn[p.channel] = c;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall_q) begin
        in_valid <= 1'b0;
        gap_left <= pick_gap();
      end else if (!in_valid && pending_polls.size() > 0 && gap_left == 0 && !hold_off) begin
        poll_t p;
        p = pending_polls.pop_front();
        kind <= p.kind;
        channel <= p.channel;
        raw_level <= p.raw_level;
        now_ms <= p.now_ms;
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= pick_gap();
      end
    end
  end

  // handshake bookkeeping at the rising edge
  always @(posedge clk) begin
    in_stall_q <= !(!rst && in_valid && !in_stall);
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_button('{kind, channel, raw_level, now_ms}));
        sent++;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report("unexpected transaction", 0, 0);
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (channel_out !== e.channel_out)
          report("channel_out", 32'(channel_out), 32'(e.channel_out));
        if (notify_code !== e.notify_code)
          report("notify_code", 32'(notify_code), 32'(e.notify_code));
        if (event_res !== e.event_res)
          report("event_res", 32'(event_res), 32'(e.event_res));
        if (input_type !== e.input_type)
          report("input_type", 32'(input_type), 32'(e.input_type));
        if (level_out !== e.level_out)
          report("level_out", 32'(level_out), 32'(e.level_out));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || stim_done ||
        (pending_polls.size() == 0 && expected_results.size() == 0 && !in_valid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_poll(input logic k, input logic [3:0] ch, input logic lvl,
                          input logic [31:0] dt);
    clock_ms[ch] = clock_ms[ch] + dt;
    pending_polls.push_back('{k, ch, lvl, clock_ms[ch]});
  endtask

  // one press of given length followed by a release, polled at a few points
  task automatic add_press(input logic [3:0] ch, input int len, input int gap);
    add_poll(KIND_POLL, ch, 1'b1, gap);
    if ($urandom_range(0, 3) == 0) add_poll(KIND_POLL, ch, 1'b0, $urandom_range(0, 25));
    add_poll(KIND_POLL, ch, 1'b1, len / 2);
    add_poll(KIND_POLL, ch, 1'b1, len - len / 2);
    add_poll(KIND_POLL, ch, 1'b0, $urandom_range(1, 40));
  endtask

  task automatic wait_drained();
    while (pending_polls.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_cfg(idx, val);
  endtask

  task automatic random_phase(input int count);
    int done_items;
    int roll;
    logic [3:0] ch;
    done_items = 0;
    while (done_items < count) begin
      ch = 4'($urandom_range(0, 15));
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        repeat ($urandom_range(1, 5)) add_press(ch, $urandom_range(0, 700), $urandom_range(21, 400));
        add_poll(KIND_POLL, ch, 1'b0, $urandom_range(0, 600));
        add_poll(KIND_FETCH, ch, 1'($urandom_range(0, 1)), $urandom_range(0, 50));
      end else if (roll < 70) begin
        add_press(ch, $urandom_range(1500, 4000), $urandom_range(21, 100));
        add_poll(KIND_FETCH, ch, 1'b0, 1);
      end else if (roll < 90) begin
        add_poll(1'($urandom_range(0, 1)), ch, 1'($urandom_range(0, 1)),
                 $urandom_range(0, 60));
      end else begin
        pending_polls.push_back('{1'($urandom_range(0, 1)), ch, 1'($urandom_range(0, 1)),
                                  $urandom()});
      end
      done_items = pending_polls.size() + sent;
      if (pending_polls.size() > 200) while (pending_polls.size() > 50) @(posedge clk);
      done_items = sent + pending_polls.size();
      count = count;
      if (done_items >= count) break;
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) begin
      btn[i] = '0;
      clock_ms[i] = 32'd1000 * i;
    end
    win_double = 16'd350; win_multi = 16'd200; hold_len = 16'd500; min_click = 16'd50;
    max_clk = 3'd5; mom_limit = 16'd1000; min_samp = 8'd3; mom_pct = 7'd50;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes and special cases
    add_poll(KIND_POLL, 4'd0, 1'b1, 5);
    add_poll(KIND_POLL, 4'd0, 1'b1, 30);
    add_poll(KIND_POLL, 4'd0, 1'b0, 100);
    add_poll(KIND_POLL, 4'd0, 1'b0, 400);
    add_poll(KIND_FETCH, 4'd0, 1'b0, 1);
    add_poll(KIND_FETCH, 4'd0, 1'b1, 1);
    add_press(4'd15, 10, 30);
    add_press(4'd15, 100, 30);
    add_press(4'd15, 100, 30);
    add_press(4'd15, 100, 30);
    add_press(4'd15, 100, 30);
    add_press(4'd15, 100, 30);
    add_press(4'd5, 3000, 30);
    add_poll(KIND_FETCH, 4'd5, 1'b0, 1);
    pending_polls.push_back('{KIND_POLL, 4'd7, 1'b1, 32'hFFFF_FFF0});
    pending_polls.push_back('{KIND_POLL, 4'd7, 1'b0, 32'h0000_0020});
    wait_drained();
    // pause until every expected result arrived
    hold_off <= 1'b1;
    wait_drained();
    hold_off <= 1'b0;

    random_phase(200);
    wait_drained();
    write_reg(REG_DOUBLE_WIN, 16'd0);
    write_reg(REG_MULTI_WIN, 16'd0);
    write_reg(REG_HOLD, 16'hFFFF);
    write_reg(REG_MIN_CLICK, 16'd0);
    write_reg(REG_MAX_CLICKS, 16'd0);
    write_reg(REG_MOM_LIMIT, 16'd0);
    write_reg(REG_MIN_SAMPLES, 16'd1);
    write_reg(REG_MOM_PERCENT, 16'd0);
    random_phase(350);
    wait_drained();
    write_reg(REG_DOUBLE_WIN, 16'hFFFF);
    write_reg(REG_MULTI_WIN, 16'hFFFF);
    write_reg(REG_HOLD, 16'd0);
    write_reg(REG_MIN_CLICK, 16'hFFFF);
    write_reg(REG_MAX_CLICKS, 16'd7);
    write_reg(REG_MOM_LIMIT, 16'hFFFF);
    write_reg(REG_MIN_SAMPLES, 16'd255);
    write_reg(REG_MOM_PERCENT, 16'd100);
    random_phase(480);
    wait_drained();
    write_reg(REG_DOUBLE_WIN, 16'd300);
    write_reg(REG_MULTI_WIN, 16'd150);
    write_reg(REG_HOLD, 16'd800);
    write_reg(REG_MIN_CLICK, 16'd40);
    write_reg(REG_MAX_CLICKS, 16'd3);
    write_reg(REG_MOM_LIMIT, 16'd600);
    write_reg(REG_MIN_SAMPLES, 16'd2);
    write_reg(REG_MOM_PERCENT, 16'd66);
    random_phase(650);
    wait_drained();
    stim_done <= 1'b1;
    if (errors == 0 && expected_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
